// ===== hdl/rnco_pkg.sv =====
// ----------------------------------------------------------------------------
// rnco_pkg: shared types, widths and helpers for the recursive NCO mixer
// Fixed-point widths, the shared MAC request, config struct, FSM states
// and saturation helpers.
// ----------------------------------------------------------------------------
package rnco_pkg;

    localparam int SAMPLE_W = 16;
    localparam int OSC_FRAC = 16;
    localparam int OSC_W    = OSC_FRAC + 2;
    localparam int OUT_W    = SAMPLE_W + 1;
    localparam int MUL_W    = (SAMPLE_W > OSC_W) ? SAMPLE_W : OSC_W;
    localparam int ACC_W    = 2 * MUL_W + 2;
    localparam int SUM_W    = ACC_W - OSC_FRAC;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // 1.95 on the oscillator grid, rounded
    localparam longint GAIN_K = ((64'sd39 <<< OSC_FRAC) + 64'sd10) / 64'sd20;

    typedef logic signed [SAMPLE_W-1:0]  t_sample;
    typedef logic signed [OSC_W-1:0]     t_osc;
    typedef logic signed [OUT_W-1:0]     t_out;
    typedef logic signed [MUL_W-1:0]     t_mul;
    typedef logic signed [2*MUL_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]     t_acc;
    typedef logic signed [SUM_W-1:0]     t_sum;

    localparam t_sum OSC_HI = t_sum'((64'sd1 <<< (OSC_W - 1)) - 64'sd1);
    localparam t_sum OSC_LO = t_sum'(-(64'sd1 <<< (OSC_W - 1)));
    localparam t_sum OUT_HI = t_sum'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam t_sum OUT_LO = t_sum'(-(64'sd1 <<< (OUT_W - 1)));

    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        t_mul    a;
        t_mul    b;
        t_acc_op op;
    } t_mac_req;

    typedef struct packed {
        t_osc osc_cos;
        t_osc osc_sin;
        logic shift_enable;
    } t_cfg;

    typedef enum logic [1:0] {
        REG_COS,
        REG_SIN,
        REG_ENABLE
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    function automatic t_osc sat_osc(input t_sum v);
        t_sum r;
        r = v;
        if (v > OSC_HI) r = OSC_HI;
        if (v < OSC_LO) r = OSC_LO;
        return t_osc'(r);
    endfunction

    function automatic t_out sat_out(input t_sum v);
        t_sum r;
        r = v;
        if (v > OUT_HI) r = OUT_HI;
        if (v < OUT_LO) r = OUT_LO;
        return t_out'(r);
    endfunction

endpackage

// ===== hdl/rnco_mac.sv =====
// ----------------------------------------------------------------------------
// rnco_mac: shared multiply-accumulate unit
// One registered multiplier feeding an accumulator; the op travels with the
// product. o_sum is the next accumulator value floored onto the osc grid.
// ----------------------------------------------------------------------------
module rnco_mac
    import rnco_pkg::*;
(
    input  logic     i_clk,
    input  t_mac_req i_req,
    output t_sum     o_sum
);

    t_prod   w_prod;
    t_acc    r_prod;
    t_acc_op r_op;
    t_acc    r_acc;
    t_acc    n_acc;

    assign w_prod = i_req.a * i_req.b;

    always_ff @(posedge i_clk) begin
        r_prod <= t_acc'(w_prod);
        r_op   <= i_req.op;
        r_acc  <= n_acc;
    end

    always_comb begin
        unique case (r_op)
            ACC_LOAD: n_acc = r_prod;
            ACC_ADD:  n_acc = r_acc + r_prod;
            ACC_SUB:  n_acc = r_acc - r_prod;
            default:  n_acc = r_prod;
        endcase
    end

    // drop fraction bits: floor toward minus infinity
    assign o_sum = t_sum'(n_acc[ACC_W-1:OSC_FRAC]);

endmodule

// ===== hdl/rnco_regs.sv =====
// ----------------------------------------------------------------------------
// rnco_regs: configuration register file
// Phase-step cosine and sine plus the mixer enable, behind an APB-style port.
// ----------------------------------------------------------------------------
module rnco_regs
    import rnco_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.osc_cos      <= t_osc'(64'sd1 <<< OSC_FRAC);
            r_cfg.osc_sin      <= '0;
            r_cfg.shift_enable <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[ADDR_W-1:2])
                REG_COS:    r_cfg.osc_cos      <= t_osc'(pwdata[OSC_W-1:0]);
                REG_SIN:    r_cfg.osc_sin      <= t_osc'(pwdata[OSC_W-1:0]);
                REG_ENABLE: r_cfg.shift_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_COS:    prdata = DATA_W'(r_cfg.osc_cos);
            REG_SIN:    prdata = DATA_W'(r_cfg.osc_sin);
            REG_ENABLE: prdata = DATA_W'(r_cfg.shift_enable);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== hdl/recursive_nco_complex_mixer_core.sv =====
// ----------------------------------------------------------------------------
// recursive_nco_complex_mixer_core: complex mixer with recursive quadrature NCO
// When mixing is on, rotates the oscillator state each sample, renormalizes it
// with a gain of 1.95 - |state|^2 and multiplies the sample by the rotated oscillator.
//
// Usage:
//   Input words (in_re, in_im, last_in_block) are taken when i_in_valid is
//   high and o_in_stall is low. Result words leave on o_out_valid and are
//   held while i_out_stall is high; one result per input word.
//   With mixing enabled a word goes from accept to the output register by
//   twelve multiply-accumulate ops issued one per cycle through the single
//   18x18 multiplier and its accumulator, then the last writeback and the
//   hand-off state. The block takes no new word until the last one has
//   been handed off. With mixing disabled the sample skips the MAC and
//   passes through the result register to the output register.
//   o_in_stall is high while a word is in flight; the next word may enter
//   while the previous result still waits in the output register, and a
//   finished word waits in place if that register is still full.
//   Reset (synchronous, active low) loads cos = 1.0, sin = 0, mixing off,
//   oscillator state 1.0 + j0, and empties the pipeline.
//   Registers: 0x0 cos, 0x4 sin, 0x8 enable. Write them only while idle.
// ----------------------------------------------------------------------------
module recursive_nco_complex_mixer_core
    import rnco_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_sample           i_in_re,
    input  t_sample           i_in_im,
    input  logic              i_last_in_block,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_re,
    output t_out              o_out_im,
    output logic              o_last_out
);

    typedef logic [3:0] t_step;

    // issue slots of the shared MAC
    localparam t_step ISS_RE_COS = 4'd0;
    localparam t_step ISS_IM_SIN = 4'd1;
    localparam t_step ISS_IM_COS = 4'd2;
    localparam t_step ISS_RE_SIN = 4'd3;
    localparam t_step ISS_RE_SQ  = 4'd4;
    localparam t_step ISS_IM_SQ  = 4'd5;
    localparam t_step ISS_X_LORE = 4'd6;
    localparam t_step ISS_Y_LOIM = 4'd7;
    localparam t_step ISS_X_LOIM = 4'd8;
    localparam t_step ISS_Y_LORE = 4'd9;
    localparam t_step ISS_G_LORE = 4'd10;
    localparam t_step ISS_G_LOIM = 4'd11;
    // writeback slots: the op issued one slot earlier completes here
    localparam t_step WB_LO_RE   = 4'd2;
    localparam t_step WB_LO_IM   = 4'd4;
    localparam t_step WB_MAG     = 4'd6;
    localparam t_step WB_GAIN    = 4'd7;
    localparam t_step WB_OUT_RE  = 4'd8;
    localparam t_step WB_OUT_IM  = 4'd10;
    localparam t_step WB_OSC_RE  = 4'd11;
    localparam t_step WB_OSC_IM  = 4'd12;

    t_cfg     w_cfg;
    t_mac_req w_req;
    t_sum     w_sum;
    logic     w_in_acc;
    logic     w_out_free;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    t_sample r_x, n_x, r_y, n_y;
    logic   r_last, n_last;
    t_osc   r_osc_re, n_osc_re, r_osc_im, n_osc_im;
    t_osc   r_lo_re, n_lo_re, r_lo_im, n_lo_im;
    t_sum   r_mag, n_mag;
    t_osc   r_gain, n_gain;
    t_out   r_res_re, n_res_re, r_res_im, n_res_im;
    logic   r_out_valid, n_out_valid;
    t_out   r_out_re, n_out_re, r_out_im, n_out_im;
    logic   r_out_last, n_out_last;

    rnco_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rnco_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_sum (w_sum)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;
    assign o_last_out  = r_out_last;

    // operand select for the shared MAC
    always_comb begin
        w_req = '{a: '0, b: '0, op: ACC_LOAD};
        if (r_state == S_RUN) begin
            case (r_step)
                ISS_RE_COS: w_req = '{t_mul'(r_osc_re), t_mul'(w_cfg.osc_cos), ACC_LOAD};
                ISS_IM_SIN: w_req = '{t_mul'(r_osc_im), t_mul'(w_cfg.osc_sin), ACC_SUB};
                ISS_IM_COS: w_req = '{t_mul'(r_osc_im), t_mul'(w_cfg.osc_cos), ACC_LOAD};
                ISS_RE_SIN: w_req = '{t_mul'(r_osc_re), t_mul'(w_cfg.osc_sin), ACC_ADD};
                ISS_RE_SQ:  w_req = '{t_mul'(r_osc_re), t_mul'(r_osc_re), ACC_LOAD};
                ISS_IM_SQ:  w_req = '{t_mul'(r_osc_im), t_mul'(r_osc_im), ACC_ADD};
                ISS_X_LORE: w_req = '{t_mul'(r_x), t_mul'(r_lo_re), ACC_LOAD};
                ISS_Y_LOIM: w_req = '{t_mul'(r_y), t_mul'(r_lo_im), ACC_SUB};
                ISS_X_LOIM: w_req = '{t_mul'(r_x), t_mul'(r_lo_im), ACC_LOAD};
                ISS_Y_LORE: w_req = '{t_mul'(r_y), t_mul'(r_lo_re), ACC_ADD};
                ISS_G_LORE: w_req = '{t_mul'(r_gain), t_mul'(r_lo_re), ACC_LOAD};
                ISS_G_LOIM: w_req = '{t_mul'(r_gain), t_mul'(r_lo_im), ACC_LOAD};
                default:    w_req = '{a: '0, b: '0, op: ACC_LOAD};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_osc_re    <= t_osc'(64'sd1 <<< OSC_FRAC);
            r_osc_im    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_osc_re    <= n_osc_re;
            r_osc_im    <= n_osc_im;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_last     <= n_last;
        r_lo_re    <= n_lo_re;
        r_lo_im    <= n_lo_im;
        r_mag      <= n_mag;
        r_gain     <= n_gain;
        r_res_re   <= n_res_re;
        r_res_im   <= n_res_im;
        r_out_re   <= n_out_re;
        r_out_im   <= n_out_im;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_x         = r_x;
        n_y         = r_y;
        n_last      = r_last;
        n_osc_re    = r_osc_re;
        n_osc_im    = r_osc_im;
        n_lo_re     = r_lo_re;
        n_lo_im     = r_lo_im;
        n_mag       = r_mag;
        n_gain      = r_gain;
        n_res_re    = r_res_re;
        n_res_im    = r_res_im;
        n_out_valid = r_out_valid;
        n_out_re    = r_out_re;
        n_out_im    = r_out_im;
        n_out_last  = r_out_last;

        // release the output word once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_x      = i_in_re;
                    n_y      = i_in_im;
                    n_last   = i_last_in_block;
                    n_res_re = t_out'(i_in_re);
                    n_res_im = t_out'(i_in_im);
                    n_step   = '0;
                    n_state  = w_cfg.shift_enable ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                n_step = r_step + t_step'(1);
                case (r_step)
                    WB_LO_RE:  n_lo_re  = sat_osc(w_sum);
                    WB_LO_IM:  n_lo_im  = sat_osc(w_sum);
                    WB_MAG:    n_mag    = w_sum;
                    WB_GAIN:   n_gain   = sat_osc(t_sum'(GAIN_K) - r_mag);
                    WB_OUT_RE: n_res_re = sat_out(w_sum);
                    WB_OUT_IM: n_res_im = sat_out(w_sum);
                    WB_OSC_RE: n_osc_re = sat_osc(w_sum);
                    WB_OSC_IM: begin
                        n_osc_im = sat_osc(w_sum);
                        n_state  = S_DONE;
                    end
                    default: ;
                endcase
            end
            S_DONE: begin
                // hold the finished word until the output register frees up
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_re    = r_res_re;
                    n_out_im    = r_res_im;
                    n_out_last  = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_bypass_holds_osc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_cfg.shift_enable)
        |=> (r_state == S_DONE) && $stable(r_osc_re) && $stable(r_osc_im))
        else $error("bypass word must skip the MAC and keep the oscillator");

    a_run_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step == WB_OSC_IM) |=> (r_state == S_DONE))
        else $error("sequencer must finish after the last writeback");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_step <= WB_OSC_IM))
        else $error("step counter ran past the schedule");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_state == S_DONE)
        |=> (r_state == S_DONE) && $stable(r_out_re) && $stable(r_out_im))
        else $error("pending output word overwritten");

endmodule

// ===== bench/recursive_nco_complex_mixer_core_test.sv =====
// ----------------------------------------------------------------------------
// recursive_nco_complex_mixer_core_test: self-checking bench for the NCO mixer
// Drives complex sample words with bursty valid, stalls the result side on a
// random pattern with one long hold, and checks every result word field by
// field against a bit-exact fixed-point model of the oscillator and mixer.
// Runs pass-through, quarter/half turn, random-angle and out-of-range settings.
// ----------------------------------------------------------------------------
module recursive_nco_complex_mixer_core_test;
    import rnco_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        t_sample re;
        t_sample im;
        logic    last;
    } t_sample_word;

    typedef struct packed {
        t_out re;
        t_out im;
        logic last;
    } t_mixed_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_sample           i_in_re = '0;
    t_sample           i_in_im = '0;
    logic              i_last_in_block = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out              o_out_re;
    t_out              o_out_im;
    logic              o_last_out;

    recursive_nco_complex_mixer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_re         (i_in_re),
        .i_in_im         (i_in_im),
        .i_last_in_block (i_last_in_block),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_re        (o_out_re),
        .o_out_im        (o_out_im),
        .o_last_out      (o_last_out)
    );

    always #5 i_clk = ~i_clk;

    // model state and register copies
    longint osc_re_m;
    longint osc_im_m;
    longint cos_m;
    longint sin_m;
    bit     mix_on_m;

    t_sample_word sample_fifo[$];
    t_mixed_word  mixed_fifo[$];
    t_sample_word cur_word;

    int gap_max = 3;
    int stall_pct = 30;
    int burst_left = 0;
    int gap_left = 0;
    int taken_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int fail_cnt = 0;
    int cycle_cnt = 0;

    function automatic longint clip(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Rotate the oscillator, renormalize it and mix one sample word.
    function automatic t_mixed_word mix_sample(t_sample_word w);
        longint x, y, lo_re, lo_im, gain, ore, oim;
        t_mixed_word r;
        x   = longint'(w.re);
        y   = longint'(w.im);
        ore = x;
        oim = y;
        if (mix_on_m) begin
            lo_re = clip((osc_re_m * cos_m - osc_im_m * sin_m) >>> OSC_FRAC, OSC_W);
            lo_im = clip((osc_im_m * cos_m + osc_re_m * sin_m) >>> OSC_FRAC, OSC_W);
            gain  = clip(GAIN_K - ((osc_re_m * osc_re_m + osc_im_m * osc_im_m) >>> OSC_FRAC),
                         OSC_W);
            osc_re_m = clip((gain * lo_re) >>> OSC_FRAC, OSC_W);
            osc_im_m = clip((gain * lo_im) >>> OSC_FRAC, OSC_W);
            ore = (x * lo_re - y * lo_im) >>> OSC_FRAC;
            oim = (x * lo_im + y * lo_re) >>> OSC_FRAC;
        end
        r.re   = t_out'(clip(ore, OUT_W));
        r.im   = t_out'(clip(oim, OUT_W));
        r.last = w.last;
        return r;
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(15))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3: return '1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic queue_sample(t_sample re, t_sample im, logic last);
        t_sample_word w;
        w.re   = re;
        w.im   = im;
        w.last = last;
        sample_fifo.push_back(w);
    endtask

    task automatic write_reg(t_reg_idx idx, longint val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COS:    cos_m = longint'(t_osc'(val));
            REG_SIN:    sin_m = longint'(t_osc'(val));
            REG_ENABLE: mix_on_m = val[0];
            default:    ;
        endcase
    endtask

    // Wait until every queued word went in and every result word came out.
    task automatic drain();
        while (sample_fifo.size() != 0 || i_in_valid || mixed_fifo.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // sender: bursts of words with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                mixed_fifo.push_back(mix_sample(cur_word));
            end
            // hold the word while it is stalled
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (sample_fifo.size() > 0) begin
                    cur_word = sample_fifo.pop_front();
                    i_in_re         <= cur_word.re;
                    i_in_im         <= cur_word.im;
                    i_last_in_block <= cur_word.last;
                    i_in_valid      <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        if (gap_max > 0) gap_left = $urandom_range(0, gap_max);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall pattern plus one long hold to fill the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) taken_cnt++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (taken_cnt == 200 && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 300;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_mixed_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mixed_fifo.size() == 0) begin
                $error("unexpected word: out_re %0d out_im %0d", o_out_re, o_out_im);
                fail_cnt++;
            end else begin
                want = mixed_fifo.pop_front();
                if (o_out_re !== want.re) begin
                    $error("out_re: expected %0d, actual %0d", want.re, o_out_re);
                    fail_cnt++;
                end
                if (o_out_im !== want.im) begin
                    $error("out_im: expected %0d, actual %0d", want.im, o_out_im);
                    fail_cnt++;
                end
                if (o_last_out !== want.last) begin
                    $error("last_out: expected %0d, actual %0d", want.last, o_last_out);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        real ang;
        osc_re_m = longint'(1) <<< OSC_FRAC;
        osc_im_m = 0;
        cos_m    = longint'(1) <<< OSC_FRAC;
        sin_m    = 0;
        mix_on_m = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through after reset
        queue_sample(16'sh7fff, 16'sh8000, 1'b1);
        queue_sample(16'sh8000, 16'sh7fff, 1'b0);
        queue_sample('0, '0, 1'b1);
        queue_sample('1, '1, 1'b0);
        drain();

        // identity rotation, then quarter turn, then half turn, then eighth turn
        write_reg(REG_ENABLE, 1);
        queue_sample(16'sh7fff, 16'sh7fff, 1'b0);
        queue_sample(16'sh8000, 16'sh8000, 1'b1);
        queue_sample(16'sd1, -16'sd1, 1'b0);
        drain();
        write_reg(REG_COS, 0);
        write_reg(REG_SIN, 65536);
        queue_sample(16'sh7fff, 16'sh8000, 1'b1);
        queue_sample(16'sh8000, 16'sh8000, 1'b0);
        queue_sample(16'sd12345, -16'sd12345, 1'b1);
        drain();
        write_reg(REG_COS, -65536);
        write_reg(REG_SIN, 0);
        queue_sample(16'sh8000, 16'sh7fff, 1'b0);
        queue_sample(16'sh7fff, 16'sh7fff, 1'b1);
        drain();
        write_reg(REG_COS, 46341);
        write_reg(REG_SIN, -46341);
        queue_sample(16'sh8000, 16'sh8000, 1'b0);
        queue_sample(16'sh7fff, 16'sh8000, 1'b1);
        drain();
        // oscillator holds while mixing is off
        write_reg(REG_ENABLE, 0);
        queue_sample(16'sd1000, -16'sd2000, 1'b0);
        queue_sample(16'sh8000, 16'sh7fff, 1'b1);
        drain();

        for (int p = 0; p < 7; p++) begin
            gap_max   = (p == 0) ? 0 : $urandom_range(1, 20);
            stall_pct = (p == 0) ? 0 : $urandom_range(10, 70);
            ang = $urandom_range(0, 62831) / 10000.0;
            write_reg(REG_COS, $rtoi($cos(ang) * 65536.0));
            write_reg(REG_SIN, $rtoi($sin(ang) * 65536.0));
            write_reg(REG_ENABLE, (p == 4) ? 0 : 1);
            repeat (150) queue_sample(pick_sample(), pick_sample(), 1'($urandom));
            drain();
        end

        // Out-of-range steps drive the oscillator into saturation for good,
        // so run them last: LO, gain, state and output all clip here.
        gap_max   = 2;
        stall_pct = 40;
        write_reg(REG_COS, 131071);
        write_reg(REG_SIN, 131071);
        write_reg(REG_ENABLE, 1);
        queue_sample(16'sh7fff, 16'sh7fff, 1'b1);
        queue_sample(16'sh8000, 16'sh7fff, 1'b0);
        queue_sample(16'sh7fff, 16'sh8000, 1'b1);
        queue_sample(16'sh8000, 16'sh8000, 1'b0);
        drain();
        write_reg(REG_COS, -131072);
        write_reg(REG_SIN, -131072);
        queue_sample(16'sh7fff, 16'sh7fff, 1'b0);
        queue_sample(16'sh8000, 16'sh7fff, 1'b1);
        queue_sample(16'sh7fff, 16'sh8000, 1'b0);
        queue_sample(16'sh8000, 16'sh8000, 1'b1);
        drain();

        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && mixed_fifo.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
